[design/ncf_pkg.sv]
// Package for the nodal contact force block: register indexes, reset values,
// datapath widths and pipeline stage counts. No dependencies.
`default_nettype none

package ncf_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRICTION_FIRST  = 2'd0,
    REG_FRICTION_SECOND = 2'd1,
    REG_INVERSE_STEP    = 2'd2,
    REG_CELL_SIZE       = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] FRICTION_RST     = 16'h0000;
  localparam logic [31:0] INVERSE_STEP_RST = 32'h0001_0000;
  localparam logic [31:0] CELL_SIZE_RST    = 32'h0001_0000;

  // force divide: 96-bit numerator, 49-bit divisor, 32 quotient bits
  localparam int unsigned FNUM_W = 96;
  localparam int unsigned FDEN_W = 49;
  localparam int unsigned FQUO_W = 32;

  // tangential/normal magnitudes and their square roots
  localparam int unsigned MAG_W  = 35;
  localparam int unsigned ROOT_W = 36;

  // friction clip divide
  localparam int unsigned CNUM_W = MAG_W + ROOT_W;
  localparam int unsigned CQUO_W = MAG_W;

  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned MID_STAGES   = 7;
  localparam int unsigned BACK_STAGES  = 2;
  localparam int unsigned PIPE_DEPTH   = FRONT_STAGES + FQUO_W + MID_STAGES + ROOT_W +
                                         BACK_STAGES + CQUO_W;

endpackage

`default_nettype wire

[design/nodal_contact_force_with_friction.sv]
// Nodal contact force with Coulomb friction, top level.
// Uses ncf_pkg, ncf_udiv and ncf_isqrt.
//
// One two-body grid node enters per in_ beat; one result leaves per out_ beat.
// Both channels are valid/ready. The datapath is a 117-stage pipeline:
// 5 front stages (momentum exchange, approach test), a 32-stage force divider,
// 7 stages of normal/tangential split, a 36-stage square root, 2 stages for the
// friction limit and a 35-stage clip divider, then the output register.
// Throughput is one node per cycle as long as the pipeline is not frozen by a stall.
// When the receiver stalls, a waiting result sits in the output register and
// the pipeline keeps moving as long as its last stage is empty; once it holds
// a result too, the whole pipeline freezes and in_ready drops.
// Reset (rst_n low at an edge) empties the pipeline and loads the register
// reset values. Configuration writes via cfg_we take effect at once and must
// only happen while no node is in flight.
`default_nettype none

module nodal_contact_force_with_friction (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [ncf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ncf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic        [31:0]                in_mass_master,
  input  wire logic        [31:0]                in_mass_slave,
  input  wire logic signed [31:0]                in_momentum_master_x,
  input  wire logic signed [31:0]                in_momentum_master_y,
  input  wire logic signed [31:0]                in_momentum_master_z,
  input  wire logic signed [31:0]                in_momentum_slave_x,
  input  wire logic signed [31:0]                in_momentum_slave_y,
  input  wire logic signed [31:0]                in_momentum_slave_z,
  input  wire logic signed [15:0]                in_normal_x,
  input  wire logic signed [15:0]                in_normal_y,
  input  wire logic signed [15:0]                in_normal_z,
  input  wire logic        [31:0]                in_gap_sum,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_in_contact,
  output logic signed [31:0]                     out_force_x,
  output logic signed [31:0]                     out_force_y,
  output logic signed [31:0]                     out_force_z
);

  localparam int unsigned DEPTH  = ncf_pkg::PIPE_DEPTH;
  localparam int unsigned FQUO_W = ncf_pkg::FQUO_W;
  localparam int unsigned ROOT_W = ncf_pkg::ROOT_W;
  localparam int unsigned CQUO_W = ncf_pkg::CQUO_W;
  localparam int unsigned MAG_W  = ncf_pkg::MAG_W;

  typedef struct packed {
    logic             contact;
    logic [2:0]       ovf;
    logic [2:0]       fneg;
    logic [2:0][15:0] nrm;
  } side_a_t;

  typedef struct packed {
    logic                   contact;
    logic [2:0][36:0]       ft;
    logic [2:0][35:0]       fn;
    logic [2:0][MAG_W-1:0]  amag;
  } side_b_t;

  typedef struct packed {
    logic             contact;
    logic             clip;
    logic [2:0][36:0] ft;
    logic [2:0][35:0] fn;
  } side_c_t;

  // configuration
  logic [15:0] fric_a_r, fric_b_r;
  logic [31:0] inv_step_r, cell_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fric_a_r    <= ncf_pkg::FRICTION_RST;
      fric_b_r    <= ncf_pkg::FRICTION_RST;
      inv_step_r  <= ncf_pkg::INVERSE_STEP_RST;
      cell_size_r <= ncf_pkg::CELL_SIZE_RST;
    end else if (cfg_we) begin
      unique case (ncf_pkg::cfg_reg_t'(cfg_index))
        ncf_pkg::REG_FRICTION_FIRST:  fric_a_r    <= cfg_data[15:0];
        ncf_pkg::REG_FRICTION_SECOND: fric_b_r    <= cfg_data[15:0];
        ncf_pkg::REG_INVERSE_STEP:    inv_step_r  <= cfg_data;
        ncf_pkg::REG_CELL_SIZE:       cell_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  logic [DEPTH-1:0] vld_r;
  logic             out_valid_r;
  logic             slot_free;
  logic             adv;

  assign slot_free = !out_valid_r || out_ready;
  assign adv       = slot_free || !vld_r[DEPTH-1];
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[DEPTH-2:0], in_valid};
      end
      if (slot_free) begin
        out_valid_r <= vld_r[DEPTH-1];
      end
    end
  end

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [15:0] nin [3];

  assign pa[0]  = in_momentum_master_x;
  assign pa[1]  = in_momentum_master_y;
  assign pa[2]  = in_momentum_master_z;
  assign pb[0]  = in_momentum_slave_x;
  assign pb[1]  = in_momentum_slave_y;
  assign pb[2]  = in_momentum_slave_z;
  assign nin[0] = in_normal_x;
  assign nin[1] = in_normal_y;
  assign nin[2] = in_normal_z;

  // stage 1: cross products of mass and momentum
  logic signed [63:0] pm1_r [3];
  logic signed [63:0] ps1_r [3];
  logic signed [15:0] nrm1_r [3];
  logic [32:0]        total1_r;
  logic               gap1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pm1_r[i]  <= $signed({1'b0, in_mass_slave}) * pa[i];
        ps1_r[i]  <= $signed({1'b0, in_mass_master}) * pb[i];
        nrm1_r[i] <= nin[i];
      end
      total1_r <= {1'b0, in_mass_master} + {1'b0, in_mass_slave};
      gap1_r   <= {in_gap_sum, 1'b0} <= {1'b0, cell_size_r};
    end
  end

  // stage 2: momentum difference
  logic signed [64:0] d2_r [3];
  logic signed [15:0] nrm2_r [3];
  logic [32:0]        total2_r;
  logic               gap2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d2_r[i]   <= $signed({pm1_r[i][63], pm1_r[i]}) - $signed({ps1_r[i][63], ps1_r[i]});
        nrm2_r[i] <= nrm1_r[i];
      end
      total2_r <= total1_r;
      gap2_r   <= gap1_r;
    end
  end

  // stage 3: normal projection partials, magnitude of the difference
  logic signed [48:0] pl3_r [3];
  logic signed [48:0] ph3_r [3];
  logic [63:0]        dmag3_r [3];
  logic [2:0]         fneg3_r;
  logic signed [15:0] nrm3_r [3];
  logic [32:0]        total3_r;
  logic               gap3_r;
  logic [64:0]        dneg2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg2[i] = ~d2_r[i] + 65'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pl3_r[i]   <= nrm2_r[i] * $signed({1'b0, d2_r[i][31:0]});
        ph3_r[i]   <= nrm2_r[i] * $signed(d2_r[i][64:32]);
        dmag3_r[i] <= d2_r[i][64] ? dneg2[i][63:0] : d2_r[i][63:0];
        fneg3_r[i] <= !d2_r[i][64];
        nrm3_r[i]  <= nrm2_r[i];
      end
      total3_r <= total2_r;
      gap3_r   <= gap2_r;
    end
  end

  // stage 4: approach test, numerator partials
  logic [82:0]        s4;
  logic               contact4;
  logic [63:0]        nlo4_r [3];
  logic [63:0]        nhi4_r [3];
  logic [2:0]         fneg4_r;
  logic signed [15:0] nrm4_r [3];
  logic [32:0]        total4_r;
  logic               contact4_r;

  always_comb begin
    s4 = '0;
    for (int i = 0; i < 3; i++) begin
      s4 = s4 + ({{34{ph3_r[i][48]}}, ph3_r[i]} << 32) + {{34{pl3_r[i][48]}}, pl3_r[i]};
    end
    contact4 = (total3_r != '0) && !s4[82] && (s4 != '0) && gap3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nlo4_r[i] <= dmag3_r[i][31:0] * inv_step_r;
        nhi4_r[i] <= dmag3_r[i][63:32] * inv_step_r;
        nrm4_r[i] <= nrm3_r[i];
      end
      fneg4_r    <= fneg3_r;
      total4_r   <= total3_r;
      contact4_r <= contact4;
    end
  end

  // stage 5: full numerator, divisor, overflow check
  logic [95:0]        num5 [3];
  logic [48:0]        den5;
  logic [95:0]        num5_r [3];
  logic [48:0]        den5_r;
  side_a_t            sa5_r;

  always_comb begin
    den5 = {total4_r, 16'd0};
    for (int i = 0; i < 3; i++) begin
      num5[i] = {32'd0, nlo4_r[i]} + {nhi4_r[i], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num5_r[i]     <= num5[i];
        sa5_r.ovf[i]  <= num5[i] >= {15'd0, den5, 32'd0};
        sa5_r.nrm[i]  <= nrm4_r[i];
      end
      den5_r        <= den5;
      sa5_r.fneg    <= fneg4_r;
      sa5_r.contact <= contact4_r;
    end
  end

  // force divide
  logic [FQUO_W-1:0] fq [3];
  side_a_t           sa_r [FQUO_W];

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    ncf_udiv #(
      .NUM_W (ncf_pkg::FNUM_W),
      .DEN_W (ncf_pkg::FDEN_W),
      .QUO_W (FQUO_W)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (num5_r[i]),
      .den (den5_r),
      .quo (fq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r[0] <= sa5_r;
      for (int k = 1; k < FQUO_W; k++) begin
        sa_r[k] <= sa_r[k-1];
      end
    end
  end

  // stage 6: saturate force
  side_a_t            sa6;
  logic signed [31:0] f6 [3];
  logic signed [31:0] f6_r [3];
  logic signed [15:0] nrm6_r [3];
  logic               contact6_r;

  always_comb begin
    sa6 = sa_r[FQUO_W-1];
    for (int i = 0; i < 3; i++) begin
      if (sa6.fneg[i]) begin
        f6[i] = (sa6.ovf[i] || fq[i] > 32'h8000_0000) ? 32'sh8000_0000 : $signed(~fq[i] + 32'd1);
      end else begin
        f6[i] = (sa6.ovf[i] || fq[i] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(fq[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f6_r[i]   <= f6[i];
        nrm6_r[i] <= $signed(sa6.nrm[i]);
      end
      contact6_r <= sa6.contact;
    end
  end

  // stage 7: force along normal, per axis
  logic signed [47:0] p7_r [3];
  logic signed [31:0] f7_r [3];
  logic signed [15:0] nrm7_r [3];
  logic               contact7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p7_r[i]   <= f6_r[i] * nrm6_r[i];
        f7_r[i]   <= f6_r[i];
        nrm7_r[i] <= nrm6_r[i];
      end
      contact7_r <= contact6_r;
    end
  end

  // stage 8: normal scalar, truncated toward zero
  logic [49:0]        fs8;
  logic [49:0]        fsb8;
  logic signed [34:0] fsq8_r;
  logic signed [31:0] f8_r [3];
  logic signed [15:0] nrm8_r [3];
  logic               contact8_r;

  always_comb begin
    fs8 = '0;
    for (int i = 0; i < 3; i++) begin
      fs8 = fs8 + {{2{p7_r[i][47]}}, p7_r[i]};
    end
    fsb8 = fs8 + (fs8[49] ? 50'd16383 : 50'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fsq8_r <= $signed(fsb8[48:14]);
      for (int i = 0; i < 3; i++) begin
        f8_r[i]   <= f7_r[i];
        nrm8_r[i] <= nrm7_r[i];
      end
      contact8_r <= contact7_r;
    end
  end

  // stage 9: normal component per axis
  logic signed [50:0] pn9 [3];
  logic [50:0]        pnb9 [3];
  logic signed [35:0] fn9_r [3];
  logic signed [31:0] f9_r [3];
  logic               contact9_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pn9[i]  = fsq8_r * nrm8_r[i];
      pnb9[i] = pn9[i] + (pn9[i][50] ? 51'd16383 : 51'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        fn9_r[i] <= $signed(pnb9[i][49:14]);
        f9_r[i]  <= f8_r[i];
      end
      contact9_r <= contact8_r;
    end
  end

  // stage 10: tangential component and magnitudes
  logic [36:0]       ft10 [3];
  logic [36:0]       ftn10 [3];
  logic [35:0]       fnn10 [3];
  logic [36:0]       ft10_r [3];
  logic [35:0]       fn10_r [3];
  logic [MAG_W-1:0]  am10_r [3];
  logic [MAG_W-1:0]  bm10_r [3];
  logic              contact10_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ft10[i]  = {{5{f9_r[i][31]}}, f9_r[i]} - {fn9_r[i][35], fn9_r[i]};
      ftn10[i] = ~ft10[i] + 37'd1;
      fnn10[i] = ~fn9_r[i] + 36'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ft10_r[i] <= ft10[i];
        fn10_r[i] <= fn9_r[i];
        am10_r[i] <= ft10[i][36] ? ftn10[i][MAG_W-1:0] : ft10[i][MAG_W-1:0];
        bm10_r[i] <= fn9_r[i][35] ? fnn10[i][MAG_W-1:0] : fn9_r[i][MAG_W-1:0];
      end
      contact10_r <= contact9_r;
    end
  end

  // stage 11: squares
  logic [2*MAG_W-1:0] asq11_r [3];
  logic [2*MAG_W-1:0] bsq11_r [3];
  side_b_t            sb11_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        asq11_r[i]     <= am10_r[i] * am10_r[i];
        bsq11_r[i]     <= bm10_r[i] * bm10_r[i];
        sb11_r.ft[i]   <= ft10_r[i];
        sb11_r.fn[i]   <= fn10_r[i];
        sb11_r.amag[i] <= am10_r[i];
      end
      sb11_r.contact <= contact10_r;
    end
  end

  // stage 12: sums of squares
  logic [2*ROOT_W-1:0] tn2_12_r;
  logic [2*ROOT_W-1:0] fn2_12_r;
  side_b_t             sb12_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tn2_12_r <= (2*ROOT_W)'(asq11_r[0]) + (2*ROOT_W)'(asq11_r[1]) +
                  (2*ROOT_W)'(asq11_r[2]);
      fn2_12_r <= (2*ROOT_W)'(bsq11_r[0]) + (2*ROOT_W)'(bsq11_r[1]) +
                  (2*ROOT_W)'(bsq11_r[2]);
      sb12_r   <= sb11_r;
    end
  end

  // square roots
  logic [ROOT_W-1:0] tn_root;
  logic [ROOT_W-1:0] fn_root;
  side_b_t           sb_r [ROOT_W];

  ncf_isqrt #(.ROOT_W (ROOT_W)) u_sqrt_t (
    .clk  (clk),
    .en   (adv),
    .rad  (tn2_12_r),
    .root (tn_root)
  );

  ncf_isqrt #(.ROOT_W (ROOT_W)) u_sqrt_n (
    .clk  (clk),
    .en   (adv),
    .rad  (fn2_12_r),
    .root (fn_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= sb12_r;
      for (int k = 1; k < ROOT_W; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // stage 13: friction limit
  logic [15:0]       mu13;
  logic [51:0]       lp13;
  logic [37:0]       limit13_r;
  logic [ROOT_W-1:0] tn13_r;
  side_b_t           sb13_r;

  always_comb begin
    mu13 = (fric_a_r < fric_b_r) ? fric_a_r : fric_b_r;
    lp13 = mu13 * fn_root;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      limit13_r <= lp13[51:14];
      tn13_r    <= tn_root;
      sb13_r    <= sb_r[ROOT_W-1];
    end
  end

  // stage 14: clip decision, scaled numerators
  logic [ncf_pkg::CNUM_W-1:0] cn14_r [3];
  logic [ROOT_W-1:0]          tn14_r;
  side_c_t                    sc14_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cn14_r[i] <= sb13_r.amag[i] * limit13_r[ROOT_W-1:0];
      end
      tn14_r         <= tn13_r;
      sc14_r.contact <= sb13_r.contact;
      sc14_r.clip    <= (tn13_r != '0) && ({2'b00, tn13_r} > limit13_r);
      sc14_r.ft      <= sb13_r.ft;
      sc14_r.fn      <= sb13_r.fn;
    end
  end

  // clip divide
  logic [CQUO_W-1:0] cq [3];
  side_c_t           sc_r [CQUO_W];

  for (genvar i = 0; i < 3; i++) begin : g_cdiv
    ncf_udiv #(
      .NUM_W (ncf_pkg::CNUM_W),
      .DEN_W (ROOT_W),
      .QUO_W (CQUO_W)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (cn14_r[i]),
      .den (tn14_r),
      .quo (cq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_r[0] <= sc14_r;
      for (int k = 1; k < CQUO_W; k++) begin
        sc_r[k] <= sc_r[k-1];
      end
    end
  end

  // output: recombine and saturate
  side_c_t     sco;
  logic [36:0] cqs [3];
  logic [36:0] ftc [3];
  logic [37:0] sum [3];
  logic [31:0] frc [3];
  logic [31:0] frc_r [3];
  logic        contact_r;

  always_comb begin
    sco = sc_r[CQUO_W-1];
    for (int i = 0; i < 3; i++) begin
      cqs[i] = {2'b00, cq[i]};
      if (sco.clip) begin
        ftc[i] = sco.ft[i][36] ? (~cqs[i] + 37'd1) : cqs[i];
      end else begin
        ftc[i] = sco.ft[i];
      end
      sum[i] = {ftc[i][36], ftc[i]} + {{2{sco.fn[i][35]}}, sco.fn[i]};
      if (sum[i][37:31] == {7{sum[i][37]}}) begin
        frc[i] = sum[i][31:0];
      end else begin
        frc[i] = sum[i][37] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (!sco.contact) begin
        frc[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && vld_r[DEPTH-1]) begin
      for (int i = 0; i < 3; i++) begin
        frc_r[i] <= frc[i];
      end
      contact_r <= sco.contact;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_in_contact = contact_r;
  assign out_force_x    = $signed(frc_r[0]);
  assign out_force_y    = $signed(frc_r[1]);
  assign out_force_z    = $signed(frc_r[2]);

`ifndef SYNTHESIS
  a_no_contact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_contact |->
      out_force_x == 32'sd0 && out_force_y == 32'sd0 && out_force_z == 32'sd0)
    else $error("force nonzero without contact");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output slot");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && vld_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

[design/ncf_udiv.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Caller keeps num below den shifted by QUO_W. No dependencies.
`default_nettype none

module ncf_udiv #(
  parameter int unsigned NUM_W = 96,
  parameter int unsigned DEN_W = 49,
  parameter int unsigned QUO_W = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int unsigned BIT = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] diff;
    logic             take;

    if (k == 0) begin : g_head
      assign rem_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_link
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = CMP_W'(den_in) << BIT;
    assign take  = CMP_W'(rem_in) >= trial;
    assign diff  = CMP_W'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[NUM_W-1:0] : rem_in;
        quo_r[k] <= quo_in | (take ? (QUO_W'(1) << BIT) : '0);
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

`default_nettype wire

[design/ncf_isqrt.sv]
// Pipelined floor square root, one root bit per stage.
// No dependencies.
`default_nettype none

module ncf_isqrt #(
  parameter int unsigned ROOT_W = 36
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [2*ROOT_W-1:0] rad,
  output logic      [ROOT_W-1:0]   root
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned TW    = RAD_W + 1;

  logic [RAD_W-1:0]  rem_r [ROOT_W];
  logic [ROOT_W-1:0] res_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int unsigned BIT = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] res_in;
    logic [TW-1:0]     trial;
    logic [TW-1:0]     diff;
    logic              take;

    if (k == 0) begin : g_head
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_link
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = (TW'(res_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    assign take  = TW'(rem_in) >= trial;
    assign diff  = TW'(rem_in) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[RAD_W-1:0] : rem_in;
        res_r[k] <= res_in | (take ? (ROOT_W'(1) << BIT) : '0);
      end
    end
  end

  assign root = res_r[ROOT_W-1];

endmodule

`default_nettype wire
